[hdl/ptss_pkg.sv]
// ----------------------------------------------------------------------------
// ptss_pkg
// Shared types, constants and the microcode table of the periodic task slot
// scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package ptss_pkg;

	localparam int NUM_SLOTS_DEF = 8;
	localparam int MAX_RESULTS   = 8;
	localparam int CNT_W         = $clog2(MAX_RESULTS + 1);

	typedef enum logic [1:0] {
		ACT_ADD  = 2'd0,
		ACT_TICK = 2'd1,
		ACT_DISP = 2'd2,
		ACT_NONE = 2'd3
	} act_t;

	typedef enum logic {
		KIND_ADD = 1'b0,
		KIND_RUN = 1'b1
	} kind_t;

	typedef struct packed {
		logic [15:0] handle;
		logic [15:0] delay;
		logic [15:0] period;
		logic [7:0]  pending;
	} ent_t;

	// microcode step addresses
	typedef logic [1:0] upc_t;
	localparam upc_t UPC_IDLE  = 2'd0;
	localparam upc_t UPC_PRIME = 2'd1;
	localparam upc_t UPC_LOOP  = 2'd2;
	localparam upc_t UPC_FIN   = 2'd3;

	typedef enum logic [1:0] {
		C_ALWAYS   = 2'd0,
		C_START    = 2'd1,
		C_SCAN_END = 2'd2,
		C_NEVER    = 2'd3
	} cond_t;

	typedef struct packed {
		logic  take_in;
		logic  rd_go;
		logic  scan;
		logic  fin;
		cond_t cond;
		upc_t  target;
	} uword_t;

	function automatic uword_t ucode_rom(input upc_t upc);
		uword_t w;
		w = '0;
		unique case (upc)
			UPC_IDLE: begin
				w.take_in = 1'b1;
				w.cond    = C_START;
				w.target  = UPC_PRIME;
			end
			UPC_PRIME: begin
				w.rd_go  = 1'b1;
				w.cond   = C_ALWAYS;
				w.target = UPC_LOOP;
			end
			UPC_LOOP: begin
				w.rd_go  = 1'b1;
				w.scan   = 1'b1;
				w.cond   = C_SCAN_END;
				w.target = UPC_FIN;
			end
			UPC_FIN: begin
				w.fin    = 1'b1;
				w.cond   = C_ALWAYS;
				w.target = UPC_IDLE;
			end
			default: w = '0;
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

[hdl/periodic_task_slot_scheduler_unit.sv]
// ----------------------------------------------------------------------------
// periodic_task_slot_scheduler_unit
// Time-triggered cooperative scheduler: slot table with add, tick and
// dispatch actions, run by a small microcoded sequencer.
// ----------------------------------------------------------------------------
// One input beat is taken at a time; a no-op action is taken without a walk.
// Add, tick and dispatch walk the slot table held in a single RAM, one slot
// per cycle: the sequencer accepts the beat, primes the read, walks the
// slots and finishes; add stops at the first free slot.
// The walk stalls while a result waits on m_tready. Slot contents read as
// zero until first written, so no clearing pass follows reset.
`default_nettype none

module periodic_task_slot_scheduler_unit #(
	parameter int NUM_SLOTS = ptss_pkg::NUM_SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // task_handle[15:0], start_delay[31:16], repeat_period[47:32]
	input  logic [1:0]  s_tuser,   // action[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // slot_found[0], slot_index[3:1], run_handle[19:4],
	                               // run_count[27:20], zero[31:28]
	output logic [0:0]  m_tuser,   // reply_kind[0]
	output logic        m_tlast
);

	localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(NUM_SLOTS - 1);
	localparam logic [ptss_pkg::CNT_W-1:0] MAX_N = ptss_pkg::CNT_W'(ptss_pkg::MAX_RESULTS);

	ptss_pkg::upc_t   upc_q;
	ptss_pkg::uword_t uw;

	ptss_pkg::act_t act_q;
	logic [15:0]    in_handle_q;
	logic [15:0]    in_delay_q;
	logic [15:0]    in_period_q;

	logic [IW-1:0]  ptr_q;
	logic [IW-1:0]  eidx_s1;
	logic [NUM_SLOTS-1:0] val_q;
	logic           found_q;
	logic [ptss_pkg::CNT_W-1:0] n_q;

	logic           hold_v_q;
	logic [2:0]     hold_idx_q;
	logic [15:0]    hold_handle_q;
	logic [7:0]     hold_count_q;

	logic           out_v_q;
	ptss_pkg::kind_t out_kind_q;
	logic           out_found_q;
	logic [2:0]     out_idx_q;
	logic [15:0]    out_handle_q;
	logic [7:0]     out_count_q;
	logic           out_last_q;

	ptss_pkg::ent_t rd_ent;
	ptss_pkg::ent_t ent;
	ptss_pkg::ent_t wr_ent;
	logic [7:0]     pend_inc;
	logic [15:0]    delay_m1;
	logic           occ;
	logic           qual;
	logic           ram_we;
	logic           s_fire;
	logic           out_free;
	logic           emit;
	logic           stall;
	logic           cond_ok;
	logic [2:0]     eidx3;

	ptss_pkg::kind_t e_kind;
	logic           e_found;
	logic [2:0]     e_idx;
	logic [15:0]    e_handle;
	logic [7:0]     e_count;
	logic           e_last;

	assign uw       = ptss_pkg::ucode_rom(upc_q);
	assign s_tready = uw.take_in;
	assign s_fire   = s_tvalid & s_tready;
	assign out_free = ~out_v_q | m_tready;
	assign eidx3    = 3'(eidx_s1);

	ptss_ram #(
		.WIDTH($bits(ptss_pkg::ent_t)),
		.DEPTH(NUM_SLOTS)
	) u_slots (
		.clk  (clk),
		.we   (ram_we),
		.waddr(eidx_s1),
		.wdata(wr_ent),
		.re   (uw.rd_go & ~stall),
		.raddr(ptr_q),
		.rdata(rd_ent)
	);

	always_comb begin
		ent      = val_q[eidx_s1] ? rd_ent : '0;
		occ      = (ent.handle != 16'd0);
		qual     = occ && (ent.pending != 8'd0) && (n_q < MAX_N);
		pend_inc = (ent.pending == 8'hFF) ? ent.pending : ent.pending + 8'd1;
		delay_m1 = ent.delay - 16'd1;
		wr_ent   = ent;
		ram_we   = 1'b0;
		emit     = 1'b0;
		e_kind   = ptss_pkg::KIND_ADD;
		e_found  = 1'b0;
		e_idx    = 3'd0;
		e_handle = 16'd0;
		e_count  = 8'd0;
		e_last   = 1'b1;
		if (uw.scan) begin
			case (act_q)
				ptss_pkg::ACT_ADD: begin
					if (!occ) begin
						wr_ent.handle  = in_handle_q;
						wr_ent.delay   = in_delay_q;
						wr_ent.period  = in_period_q;
						wr_ent.pending = 8'd0;
						ram_we  = 1'b1;
						emit    = 1'b1;
						e_found = 1'b1;
						e_idx   = eidx3;
					end
				end
				ptss_pkg::ACT_TICK: begin
					if (occ) begin
						ram_we = 1'b1;
						if (ent.delay != 16'd0) begin
							if (delay_m1 == 16'd0) begin
								wr_ent.pending = pend_inc;
								wr_ent.delay   = ent.period;
							end else begin
								wr_ent.delay = delay_m1;
							end
						end else if (ent.period != 16'd0) begin
							wr_ent.pending = pend_inc;
							wr_ent.delay   = ent.period;
						end
					end
				end
				ptss_pkg::ACT_DISP: begin
					if (qual) begin
						ram_we         = 1'b1;
						wr_ent.pending = 8'd0;
						if (ent.period == 16'd0) begin
							wr_ent.handle = 16'd0;
							wr_ent.delay  = 16'd0;
						end
						emit     = hold_v_q;
						e_kind   = ptss_pkg::KIND_RUN;
						e_idx    = hold_idx_q;
						e_handle = hold_handle_q;
						e_count  = hold_count_q;
						e_last   = 1'b0;
					end
				end
				default: ram_we = 1'b0;
			endcase
		end else if (uw.fin) begin
			if (act_q == ptss_pkg::ACT_ADD) begin
				emit = ~found_q;
			end else if (act_q == ptss_pkg::ACT_DISP) begin
				emit     = hold_v_q;
				e_kind   = ptss_pkg::KIND_RUN;
				e_idx    = hold_idx_q;
				e_handle = hold_handle_q;
				e_count  = hold_count_q;
			end
		end
		stall = emit & ~out_free;
		if (stall) begin
			ram_we = 1'b0;
		end
	end

	always_comb begin
		case (uw.cond)
			ptss_pkg::C_ALWAYS:   cond_ok = 1'b1;
			ptss_pkg::C_START:    cond_ok = s_fire && (s_tuser != ptss_pkg::ACT_NONE);
			ptss_pkg::C_SCAN_END: cond_ok = (eidx_s1 == LAST_IDX) ||
			                                ((act_q == ptss_pkg::ACT_ADD) && !occ);
			default:              cond_ok = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q    <= ptss_pkg::UPC_IDLE;
			act_q    <= ptss_pkg::ACT_NONE;
			ptr_q    <= '0;
			eidx_s1  <= '0;
			val_q    <= '0;
			found_q  <= 1'b0;
			n_q      <= '0;
			hold_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (!stall && cond_ok) begin
				upc_q <= uw.target;
			end
			if (s_fire) begin
				act_q    <= ptss_pkg::act_t'(s_tuser);
				ptr_q    <= '0;
				found_q  <= 1'b0;
				n_q      <= '0;
				hold_v_q <= 1'b0;
			end
			if (uw.rd_go && !stall) begin
				ptr_q   <= ptr_q + IW'(1);
				eidx_s1 <= ptr_q;
			end
			if (ram_we) begin
				val_q[eidx_s1] <= 1'b1;
				if (act_q == ptss_pkg::ACT_ADD) begin
					found_q <= 1'b1;
				end
			end
			if (ram_we && act_q == ptss_pkg::ACT_DISP) begin
				hold_v_q <= 1'b1;
				n_q      <= n_q + ptss_pkg::CNT_W'(1);
			end else if (uw.fin && !stall) begin
				hold_v_q <= 1'b0;
			end
			if (emit && !stall) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			in_handle_q <= s_tdata[15:0];
			in_delay_q  <= s_tdata[31:16];
			in_period_q <= s_tdata[47:32];
		end
		if (ram_we && act_q == ptss_pkg::ACT_DISP) begin
			hold_idx_q    <= eidx3;
			hold_handle_q <= ent.handle;
			hold_count_q  <= ent.pending;
		end
		if (emit && !stall) begin
			out_kind_q   <= e_kind;
			out_found_q  <= e_found;
			out_idx_q    <= e_idx;
			out_handle_q <= e_handle;
			out_count_q  <= e_count;
			out_last_q   <= e_last;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {4'd0, out_count_q, out_handle_q, out_idx_q, out_found_q};
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

	a_hold_only_disp: assert property (@(posedge clk) disable iff (!arst_n)
		hold_v_q |-> (act_q == ptss_pkg::ACT_DISP))
		else $error("dispatch hold valid outside dispatch");

	a_n_bound: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= MAX_N)
		else $error("run order count above limit");

	a_we_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (upc_q == ptss_pkg::UPC_LOOP))
		else $error("slot write outside table walk");

	a_found_add: assert property (@(posedge clk) disable iff (!arst_n)
		found_q |-> (act_q == ptss_pkg::ACT_ADD))
		else $error("add found flag set outside add");

endmodule

`default_nettype wire

[hdl/ptss_ram.sv]
// ----------------------------------------------------------------------------
// ptss_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ptss_ram #(
	parameter int WIDTH = 56,
	parameter int DEPTH = 8,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[tb/periodic_task_slot_scheduler_unit_test.sv]
// ----------------------------------------------------------------------------
// periodic_task_slot_scheduler_unit_test
// Self-checking bench for the periodic task slot scheduler: directed adds,
// ticks and dispatches, pending-count saturation and random sequences, run
// under three idle patterns. A slot-table predictor builds the expected
// replies and run orders; each output beat is checked field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_task_slot_scheduler_unit_test;
	import ptss_pkg::*;

	localparam int SLOTS = NUM_SLOTS_DEF;
	localparam int QUIET = 2 * SLOTS + 10;

	typedef struct packed {
		kind_t       kind;
		logic        found;
		logic [2:0]  idx;
		logic [15:0] handle;
		logic [7:0]  count;
		logic        last;
	} sched_reply_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;   // task_handle[15:0], start_delay[31:16], repeat_period[47:32]
	logic [1:0]  s_tuser;   // action[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;   // slot_found[0], slot_index[3:1], run_handle[19:4],
	                        // run_count[27:20], zero[31:28]
	logic [0:0]  m_tuser;   // reply_kind[0]
	logic        m_tlast;

	// predicted slot table
	logic [15:0] tab_handle[SLOTS];
	logic [15:0] tab_wait[SLOTS];
	logic [15:0] tab_period[SLOTS];
	logic [7:0]  tab_runs[SLOTS];

	sched_reply_t sched_replies[$];
	sched_reply_t want;

	int src_idle;
	int snk_idle;
	int errors;
	int n_adds, n_full, n_ticks, n_disp, n_ignored, n_checked, n_saturated;

	periodic_task_slot_scheduler_unit #(.NUM_SLOTS(SLOTS)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= snk_idle);
	end

	initial begin
		#(12 * 600000);
		$display("TEST FAILED");
		$finish;
	end

	function automatic void schedule_step(input act_t act, input logic [15:0] hnd,
	                                      input logic [15:0] dly, input logic [15:0] per);
		sched_reply_t batch[$];
		sched_reply_t r;
		bit placed;
		placed = 1'b0;
		r = '0;
		case (act)
			ACT_ADD: begin
				n_adds++;
				for (int i = 0; i < SLOTS; i++) begin
					if (!placed && tab_handle[i] == 16'd0) begin
						tab_handle[i] = hnd;
						tab_wait[i]   = dly;
						tab_period[i] = per;
						tab_runs[i]   = 8'd0;
						placed        = 1'b1;
						r.found       = 1'b1;
						r.idx         = i[2:0];
					end
				end
				if (!placed)
					n_full++;
				r.kind = KIND_ADD;
				batch.push_back(r);
			end
			ACT_TICK: begin
				n_ticks++;
				for (int i = 0; i < SLOTS; i++) begin
					if (tab_handle[i] != 16'd0) begin
						if (tab_wait[i] != 16'd0) begin
							tab_wait[i]--;
							if (tab_wait[i] == 16'd0) begin
								if (tab_runs[i] != 8'hFF)
									tab_runs[i]++;
								if (tab_period[i] != 16'd0)
									tab_wait[i] = tab_period[i];
							end
						end else if (tab_period[i] != 16'd0) begin
							if (tab_runs[i] != 8'hFF)
								tab_runs[i]++;
							tab_wait[i] = tab_period[i];
						end
					end
				end
			end
			ACT_DISP: begin
				n_disp++;
				for (int i = 0; i < SLOTS; i++) begin
					if (batch.size() < MAX_RESULTS && tab_handle[i] != 16'd0 &&
					    tab_runs[i] != 8'd0) begin
						r.kind   = KIND_RUN;
						r.found  = 1'b0;
						r.idx    = i[2:0];
						r.handle = tab_handle[i];
						r.count  = tab_runs[i];
						batch.push_back(r);
						tab_runs[i] = 8'd0;
						if (tab_period[i] == 16'd0) begin
							tab_handle[i] = 16'd0;
							tab_wait[i]   = 16'd0;
						end
					end
				end
			end
			default: n_ignored++;
		endcase
		if (batch.size() > 0)
			batch[batch.size() - 1].last = 1'b1;
		foreach (batch[k])
			sched_replies.push_back(batch[k]);
	endfunction

	function automatic void check_field(input string name, input logic [15:0] exp_v,
	                                    input logic [15:0] got_v);
		if (exp_v !== got_v) begin
			$error("%s mismatch: expected %0d, actual %0d", name, exp_v, got_v);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (sched_replies.size() == 0) begin
				$error("result beat with no reply pending: tdata %h tuser %b last %b",
				       m_tdata, m_tuser, m_tlast);
				errors++;
			end else begin
				want = sched_replies.pop_front();
				n_checked++;
				if (want.kind == KIND_RUN && want.count == 8'hFF)
					n_saturated++;
				check_field("reply_kind", want.kind, m_tuser[0]);
				check_field("slot_found", want.found, m_tdata[0]);
				check_field("slot_index", want.idx, m_tdata[3:1]);
				check_field("run_handle", want.handle, m_tdata[19:4]);
				check_field("run_count", want.count, m_tdata[27:20]);
				check_field("pad", 16'd0, m_tdata[31:28]);
				check_field("last_result", want.last, m_tlast);
			end
		end
	end

	task automatic send_beat(input act_t act, input logic [15:0] hnd,
	                         input logic [15:0] dly, input logic [15:0] per);
		while ($urandom_range(99) < src_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {per, dly, hnd};
		do
			@(posedge clk);
		while (!s_tready);
		schedule_step(act, hnd, dly, per);
	endtask

	task automatic wait_quiet();
		s_tvalid <= 1'b0;
		while (sched_replies.size() != 0)
			@(posedge clk);
		repeat (QUIET) @(posedge clk);
	endtask

	function automatic int periodic_slots();
		int n;
		n = 0;
		for (int i = 0; i < SLOTS; i++)
			if (tab_handle[i] != 16'd0 && tab_period[i] != 16'd0)
				n++;
		return n;
	endfunction

	// fresh table: nothing to dispatch, unused code ignored
	task automatic test_empty_table();
		send_beat(ACT_DISP, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_beat(ACT_NONE, 16'hA5A5, 16'h5A5A, 16'hFFFF);
		wait_quiet();
	endtask

	// fill all slots with one-shots, overflow, then fire and free all of them
	task automatic test_fill_and_free();
		send_beat(ACT_ADD, 16'hFFFF, 16'd1, 16'd0);
		send_beat(ACT_ADD, 16'h0001, 16'd1, 16'd0);
		send_beat(ACT_ADD, 16'h8000, 16'd1, 16'd0);
		send_beat(ACT_ADD, 16'h7FFF, 16'd1, 16'd0);
		send_beat(ACT_ADD, 16'hAAAA, 16'd1, 16'd0);
		send_beat(ACT_ADD, 16'h5555, 16'd1, 16'd0);
		send_beat(ACT_ADD, 16'h00FF, 16'd1, 16'd0);
		send_beat(ACT_ADD, 16'hFF00, 16'd1, 16'd0);
		send_beat(ACT_ADD, 16'h1234, 16'd2, 16'd3);
		send_beat(ACT_TICK, 16'd0, 16'd0, 16'd0);
		send_beat(ACT_DISP, 16'd0, 16'd0, 16'd0);
		wait_quiet();
	endtask

	// handle zero, zero-delay one-shot, zero-delay periodic, widest values
	task automatic test_standing_tasks();
		send_beat(ACT_ADD, 16'h0000, 16'd3, 16'd3);
		send_beat(ACT_ADD, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_beat(ACT_ADD, 16'h0001, 16'd0, 16'd0);
		send_beat(ACT_ADD, 16'h8000, 16'd0, 16'd1);
		send_beat(ACT_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_beat(ACT_TICK, 16'd0, 16'd0, 16'd0);
		send_beat(ACT_DISP, 16'd0, 16'd0, 16'd0);
		send_beat(ACT_DISP, 16'd0, 16'd0, 16'd0);
		wait_quiet();
	endtask

	// long tick run drives the period-1 task's pending count into saturation
	task automatic test_saturation();
		repeat (258)
			send_beat(ACT_TICK, 16'($urandom), 16'($urandom), 16'($urandom));
		send_beat(ACT_DISP, 16'd0, 16'd0, 16'd0);
		wait_quiet();
	endtask

	task automatic test_random(input int n_items);
		int pick;
		logic [15:0] hnd, dly, per;
		for (int k = 0; k < n_items; k++) begin
			pick = $urandom_range(99);
			if (pick < 32) begin
				pick = $urandom_range(99);
				if (pick < 5)
					hnd = 16'h0000;
				else if (pick < 10)
					hnd = 16'hFFFF;
				else
					hnd = 16'($urandom_range(1, 65535));
				if (periodic_slots() < 4 && $urandom_range(99) < 6) begin
					dly = 16'($urandom_range(0, 4));
					per = 16'($urandom_range(1, 6));
				end else begin
					dly = 16'($urandom_range(1, 5));
					per = 16'd0;
				end
				send_beat(ACT_ADD, hnd, dly, per);
			end else if (pick < 72) begin
				send_beat(ACT_TICK, 16'($urandom), 16'($urandom), 16'($urandom));
			end else if (pick < 90) begin
				send_beat(ACT_DISP, 16'($urandom), 16'($urandom), 16'($urandom));
			end else begin
				send_beat(ACT_NONE, 16'($urandom), 16'($urandom), 16'($urandom));
			end
		end
		wait_quiet();
	endtask

	initial begin
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= ACT_NONE;
		errors   = 0;
		src_idle = 0;
		snk_idle = 0;
		for (int i = 0; i < SLOTS; i++) begin
			tab_handle[i] = '0;
			tab_wait[i]   = '0;
			tab_period[i] = '0;
			tab_runs[i]   = '0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_idle = 38;
		snk_idle = 56;
		test_empty_table();
		test_fill_and_free();
		test_standing_tasks();
		test_random(5);

		src_idle = 56;
		snk_idle = 38;
		test_saturation();
		test_random(5);

		src_idle = 0;
		snk_idle = 0;
		test_random(5);

		$display("Ran %0d adds (%0d on a full table), %0d ticks, %0d dispatches, %0d ignored",
		         n_adds, n_full, n_ticks, n_disp, n_ignored);
		$display("Checked %0d output beats, %0d run orders at the saturated count",
		         n_checked, n_saturated);
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire

[files.f]
hdl/ptss_pkg.sv
hdl/ptss_ram.sv
hdl/periodic_task_slot_scheduler_unit.sv
tb/periodic_task_slot_scheduler_unit_test.sv
